// File: rtl/pci_config_route_decoder_defines.svh
// assertion macros for the configuration route decoder
// needs clk and rst in the scope of the module that uses them
`ifndef PCI_CONFIG_ROUTE_DECODER_DEFINES_SVH
`define PCI_CONFIG_ROUTE_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCICRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCICRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pcicrd_pkg.sv
// shared types, codes and constants of the configuration route decoder
// no dependencies
package pcicrd_pkg;

  localparam int unsigned MaxRoutePorts = 8;

  localparam logic [31:0] AddrWriteMask   = 32'h80FF_FFFC;
  localparam int unsigned AddrEnableBit   = 31;
  localparam logic [31:0] ChipsetImplMask = 32'h00FF_0073;
  localparam logic [4:0]  BootDevice      = 5'h10;
  localparam logic [2:0]  FullSize        = 3'd4;

  typedef enum logic [1:0] {
    ACT_ADDR_RD = 2'd0,
    ACT_ADDR_WR = 2'd1,
    ACT_DATA_RD = 2'd2,
    ACT_DATA_WR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DEST_LOCAL   = 2'd0,
    DEST_BOOT    = 2'd1,
    DEST_CHIPSET = 2'd2,
    DEST_PORT    = 2'd3
  } dest_t;

  typedef enum logic [2:0] {
    CFG_CHIPSET_BUS     = 3'd0,
    CFG_CHIPSET_DEVICES = 3'd1,
    CFG_ROUTE_ATTACHED  = 3'd2,
    CFG_ROUTE_FIRST     = 3'd3,
    CFG_ROUTE_LAST      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  window_offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  destination;
    logic [2:0]  port_index;
    logic [7:0]  target_bus;
    logic [4:0]  target_device;
    logic [2:0]  target_function;
    logic [7:0]  target_register;
    logic        is_write;
    logic [31:0] forward_data;
    logic [31:0] read_data;
    logic [31:0] data_mask;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  chipset_bus;
    logic [31:0] chipset_devices;
    logic [7:0]  route_attached;
    logic [63:0] route_first_buses;
    logic [63:0] route_last_buses;
  } cfg_regs_t;

  typedef struct packed {
    logic        we;
    logic [31:0] value;
  } addr_upd_t;

  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    case (size)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/pcicrd_cfg_regs.sv
// configuration register file of the route decoder
// depends on pcicrd_pkg
module pcicrd_cfg_regs
  import pcicrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.chipset_bus       <= '0;
      regs.chipset_devices   <= '0;
      regs.route_attached    <= '0;
      regs.route_first_buses <= 64'h0101_0101_0101_0101;
      regs.route_last_buses  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHIPSET_BUS:     regs.chipset_bus       <= cfg_wdata[7:0];
        CFG_CHIPSET_DEVICES: regs.chipset_devices   <= cfg_wdata[31:0] & ChipsetImplMask;
        CFG_ROUTE_ATTACHED:  regs.route_attached    <= cfg_wdata[7:0];
        CFG_ROUTE_FIRST:     regs.route_first_buses <= cfg_wdata;
        CFG_ROUTE_LAST:      regs.route_last_buses  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/pcicrd_decode.sv
// decode of one beat: address register access, data access check and routing
// depends on pcicrd_pkg
module pcicrd_decode
  import pcicrd_pkg::*;
#(
  parameter int unsigned ROUTE_PORTS = MaxRoutePorts
) (
  input  in_item_t    item,
  input  logic [31:0] addr_reg,
  input  cfg_regs_t   regs,
  output out_item_t   result,
  output addr_upd_t   addr_upd
);

  logic [31:0] mask;
  logic [31:0] addr;
  logic        size_ok;
  logic        fits;
  logic        ok;
  logic        writing;
  logic        is_data;
  logic [7:0]  bus;
  logic [4:0]  dev;
  logic        port_hit;
  logic [2:0]  port_sel;
  logic        found;
  logic [1:0]  dest;

  assign mask    = size_mask(item.access_size);
  assign addr    = addr_reg | {30'd0, item.window_offset};
  assign bus     = addr[23:16];
  assign dev     = addr[15:11];
  assign writing = (item.action == ACT_DATA_WR);
  assign is_data = (item.action == ACT_DATA_RD) || writing;
  assign size_ok = (item.access_size == 3'd1) || (item.access_size == 3'd2) ||
                   (item.access_size == FullSize);
  assign fits    = ({2'b00, item.window_offset} + {1'b0, item.access_size}) <= 4'd4;
  assign ok      = is_data && size_ok && fits && addr_reg[AddrEnableBit];

  // lowest attached port whose bus range holds the bus
  always_comb begin
    port_hit = 1'b0;
    port_sel = '0;
    for (int i = ROUTE_PORTS - 1; i >= 0; i--) begin
      if (regs.route_attached[i] &&
          bus >= regs.route_first_buses[8*i +: 8] &&
          bus <= regs.route_last_buses[8*i +: 8]) begin
        port_hit = 1'b1;
        port_sel = 3'(i);
      end
    end
  end

  always_comb begin
    dest = DEST_LOCAL;
    if (bus == 8'd0 && dev == BootDevice) begin
      dest = DEST_BOOT;
    end else if (bus == regs.chipset_bus) begin
      if (regs.chipset_devices[dev]) begin
        dest = DEST_CHIPSET;
      end
    end else if (port_hit) begin
      dest = DEST_PORT;
    end
  end

  assign found = ok && (dest != DEST_LOCAL);

  always_comb begin
    result                 = '0;
    result.data_mask       = mask;
    addr_upd.we            = (item.action == ACT_ADDR_WR) && (item.access_size == FullSize);
    addr_upd.value         = item.write_data & AddrWriteMask;
    if (item.action == ACT_ADDR_RD) begin
      result.read_data = (item.access_size == FullSize) ? addr_reg : mask;
    end else if (ok) begin
      result.target_bus      = bus;
      result.target_device   = dev;
      result.target_function = addr[10:8];
      result.target_register = addr[7:0];
      if (found) begin
        result.destination = dest;
        result.port_index  = (dest == DEST_PORT) ? port_sel : 3'd0;
        if (writing) begin
          result.is_write     = 1'b1;
          result.forward_data = item.write_data;
        end
      end else if (!writing) begin
        result.read_data = mask;
      end
    end else if (is_data && !writing) begin
      result.read_data = mask;
    end
  end

endmodule

// File: rtl/pci_config_route_decoder.sv
// a beat accepted into the input register is decoded into the result register
// throughput: one beat per cycle unless out_ready stalls; the input and result
// registers form a two-stage pipeline, so a beat is taken while a result waits
// reset (synchronous): valids, the address register and the configuration
// registers clear to their reset values; no clearing pass
// depends on pcicrd_pkg, pcicrd_cfg_regs, pcicrd_decode and the defines header
`include "pci_config_route_decoder_defines.svh"

module pci_config_route_decoder
  import pcicrd_pkg::*;
#(
  parameter int unsigned ROUTE_PORTS = MaxRoutePorts
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  cfg_regs_t   regs;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s1_advance;
  logic [31:0] addr_reg;
  out_item_t   result;
  addr_upd_t   addr_upd;

  pcicrd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  pcicrd_decode #(
    .ROUTE_PORTS (ROUTE_PORTS)
  ) u_decode (
    .item     (s1_item),
    .addr_reg (addr_reg),
    .regs     (regs),
    .result   (result),
    .addr_upd (addr_upd)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      addr_reg  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_advance && addr_upd.we) begin
        addr_reg <= addr_upd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (s1_advance) begin
      out_data <= result;
    end
  end

  `PCICRD_ASSERT_NOW(a_local_no_write, out_valid && out_data.destination == DEST_LOCAL, !out_data.is_write, "write forwarded with no target")
  `PCICRD_ASSERT_NOW(a_target_no_rdata, out_valid && out_data.destination != DEST_LOCAL, out_data.read_data == 32'd0, "local read data on a forwarded beat")
  `PCICRD_ASSERT_NOW(a_port_range, out_valid && out_data.destination == DEST_PORT, 32'(out_data.port_index) < ROUTE_PORTS, "port index beyond route ports")
  `PCICRD_ASSERT_NOW(a_addr_reserved, 1'b1, (addr_reg & ~AddrWriteMask) == 32'd0, "reserved address register bits set")
  `PCICRD_ASSERT_NEXT(a_addr_hold, !s1_advance, $stable(addr_reg), "address register changed with no beat decoded")

endmodule

// File: sim/tb_top.sv
// testbench for pci_config_route_decoder: directed and random config-space accesses,
// each beat's routing decision predicted in-bench and compared field by field
// depends on pcicrd_pkg and the decoder rtl
module tb_top
  import pcicrd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  pci_config_route_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the block's state and settings
  logic [7:0]  chip_bus = 8'd0;
  logic [31:0] chip_present = 32'd0;
  logic [7:0]  ports_attached = 8'd0;
  logic [63:0] ports_first = 64'h0101_0101_0101_0101;
  logic [63:0] ports_last = 64'd0;
  logic [31:0] addr_reg_copy = 32'd0;

  in_item_t  beats_to_send[$];
  out_item_t routes_due[$];
  int        mismatch_count = 0;
  bit        steady = 1'b0;
  int        send_gap = 0;
  int        sink_hold = 0;

  function automatic out_item_t route_access(in_item_t beat);
    out_item_t   r;
    logic [31:0] mask;
    logic [31:0] addr;
    logic        writing;
    logic        hit;
    int          sz;
    r = '0;
    sz = int'(beat.access_size);
    mask = (sz >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * sz)) - 32'd1);
    r.data_mask = mask;
    writing = (action_t'(beat.action) == ACT_DATA_WR);
    case (action_t'(beat.action))
      ACT_ADDR_RD: begin
        r.read_data = (beat.access_size == FullSize) ? addr_reg_copy : mask;
      end
      ACT_ADDR_WR: begin
        if (beat.access_size == FullSize) addr_reg_copy = beat.write_data & AddrWriteMask;
      end
      default: begin
        if ((sz == 1 || sz == 2 || sz == 4) && sz + int'(beat.window_offset) <= 4 &&
            addr_reg_copy[AddrEnableBit]) begin
          addr = addr_reg_copy | {30'd0, beat.window_offset};
          r.target_bus = addr[23:16];
          r.target_device = addr[15:11];
          r.target_function = addr[10:8];
          r.target_register = addr[7:0];
          hit = 1'b0;
          if (r.target_bus == 8'd0 && r.target_device == BootDevice) begin
            r.destination = DEST_BOOT;
            hit = 1'b1;
          end else if (r.target_bus == chip_bus) begin
            if (chip_present[r.target_device]) begin
              r.destination = DEST_CHIPSET;
              hit = 1'b1;
            end
          end else begin
            for (int i = 0; i < MaxRoutePorts; i++) begin
              if (!hit && ports_attached[i] && r.target_bus >= ports_first[8*i +: 8] &&
                  r.target_bus <= ports_last[8*i +: 8]) begin
                r.destination = DEST_PORT;
                r.port_index = i[2:0];
                hit = 1'b1;
              end
            end
          end
          if (hit) begin
            if (writing) begin
              r.is_write = 1'b1;
              r.forward_data = beat.write_data;
            end
          end else if (!writing) begin
            r.read_data = mask;
          end
        end else if (!writing) begin
          r.read_data = mask;
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_route(out_item_t want, out_item_t got);
    compare_field("destination", 32'(want.destination), 32'(got.destination));
    compare_field("port_index", 32'(want.port_index), 32'(got.port_index));
    compare_field("target_bus", 32'(want.target_bus), 32'(got.target_bus));
    compare_field("target_device", 32'(want.target_device), 32'(got.target_device));
    compare_field("target_function", 32'(want.target_function), 32'(got.target_function));
    compare_field("target_register", 32'(want.target_register), 32'(got.target_register));
    compare_field("is_write", 32'(want.is_write), 32'(got.is_write));
    compare_field("forward_data", want.forward_data, got.forward_data);
    compare_field("read_data", want.read_data, got.read_data);
    compare_field("data_mask", want.data_mask, got.data_mask);
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) routes_due.push_back(route_access(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!steady && beats_to_send.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          in_data <= beats_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (routes_due.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected beat: expected none actual %h", $time, out_data);
        end else begin
          check_route(routes_due.pop_front(), out_data);
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 11) == 0) begin
        sink_hold = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t make_beat(action_t act, int off, int sz, logic [31:0] data);
    in_item_t b;
    b.action = act;
    b.window_offset = off[1:0];
    b.access_size = sz[2:0];
    b.write_data = data;
    return b;
  endfunction

  function automatic logic [31:0] cfg_addr(bit en, int bus, int dev, int fn, int regno);
    return {en, 7'd0, bus[7:0], dev[4:0], fn[2:0], regno[7:0]};
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_CHIPSET_BUS:     chip_bus = value[7:0];
      CFG_CHIPSET_DEVICES: chip_present = value[31:0] & ChipsetImplMask;
      CFG_ROUTE_ATTACHED:  ports_attached = value[7:0];
      CFG_ROUTE_FIRST:     ports_first = value;
      CFG_ROUTE_LAST:      ports_last = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_settings(int kind);
    logic [63:0] lo;
    logic [63:0] hi;
    int a;
    int b;
    lo = '0;
    hi = '0;
    if (kind == 0) begin
      write_reg(CFG_CHIPSET_BUS, 64'hFF);
      write_reg(CFG_CHIPSET_DEVICES, 64'hFFFF_FFFF);
      write_reg(CFG_ROUTE_ATTACHED, 64'hFF);
      write_reg(CFG_ROUTE_FIRST, 64'h0);
      write_reg(CFG_ROUTE_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    end else if (kind == 1) begin
      write_reg(CFG_CHIPSET_BUS, 64'h0);
      write_reg(CFG_CHIPSET_DEVICES, 64'h0);
      write_reg(CFG_ROUTE_ATTACHED, 64'h80);
      write_reg(CFG_ROUTE_FIRST, 64'hFF00_0000_0000_0000);
      write_reg(CFG_ROUTE_LAST, 64'hFF00_0000_0000_0000);
    end else begin
      for (int i = 0; i < MaxRoutePorts; i++) begin
        a = $urandom_range(0, 255);
        if ($urandom_range(0, 4) == 0) b = $urandom_range(0, a);
        else b = a + $urandom_range(0, 24);
        if (b > 255) b = 255;
        lo[8*i +: 8] = a[7:0];
        hi[8*i +: 8] = b[7:0];
      end
      write_reg(CFG_CHIPSET_BUS, 64'($urandom_range(0, 255)));
      write_reg(CFG_CHIPSET_DEVICES, {$urandom, $urandom});
      write_reg(CFG_ROUTE_ATTACHED, {$urandom, $urandom});
      write_reg(CFG_ROUTE_FIRST, lo);
      write_reg(CFG_ROUTE_LAST, hi);
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_bus();
    logic [7:0] p;
    p = 8'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: return chip_bus;
      1: return 8'd0;
      2: return ports_first[8*p +: 8];
      3: return ports_last[8*p +: 8];
      4: return 8'($urandom_range(0, 255));
      default: return ports_last[8*p +: 8] + 8'd1;
    endcase
  endfunction

  task automatic queue_random(int count);
    int pushed;
    int sz;
    int off;
    logic [31:0] a;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 7) begin
        a = $urandom;
        a[31] = ($urandom_range(0, 15) != 0);
        a[23:16] = pick_bus();
        if ($urandom_range(0, 3) == 0) a[15:11] = BootDevice;
        beats_to_send.push_back(make_beat(ACT_ADDR_WR, $urandom_range(0, 3), 4, a));
        pushed++;
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) begin
            beats_to_send.push_back(make_beat(ACT_ADDR_RD, $urandom_range(0, 3), 4, $urandom));
          end else begin
            case ($urandom_range(0, 2))
              0: sz = 1;
              1: sz = 2;
              default: sz = 4;
            endcase
            if (sz == 4) off = 0;
            else if (sz == 2) off = 2 * $urandom_range(0, 1);
            else off = $urandom_range(0, 3);
            beats_to_send.push_back(make_beat($urandom_range(0, 1) ? ACT_DATA_WR : ACT_DATA_RD,
                                              off, sz, $urandom));
          end
          pushed++;
        end
      end else begin
        beats_to_send.push_back(make_beat(action_t'($urandom_range(0, 3)),
                                          $urandom_range(0, 3), $urandom_range(0, 4), $urandom));
        pushed++;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || routes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: enable clear, address port sizes, bootstrap, bad windows
    beats_to_send.push_back(make_beat(ACT_ADDR_RD, 0, 4, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_RD, 1, 0, 32'hFFFF_FFFF));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 0, 4, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 2, 32'hFFFF_FFFF));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 3, 4, 32'hFFFF_FFFF));
    beats_to_send.push_back(make_beat(ACT_ADDR_RD, 2, 4, 32'h0));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 3, 1, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 0, 16, 5, 8'h40)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 2, 2, 32'h0));
    beats_to_send.push_back(make_beat(ACT_DATA_WR, 0, 4, 32'hA5A5_5A5A));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 3, 2, 32'h0));
    beats_to_send.push_back(make_beat(ACT_DATA_WR, 1, 3, 32'h1234_5678));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 0, 0, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 0, 1, 0, 0)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 0, 1, 32'h0));
    wait_idle();

    // chipset bus 3, ports 1..3 attached with overlap and a reversed range
    write_reg(CFG_CHIPSET_BUS, 64'd3);
    write_reg(CFG_CHIPSET_DEVICES, 64'hFFFF_FFFF);
    write_reg(CFG_ROUTE_ATTACHED, 64'h0E);
    write_reg(CFG_ROUTE_FIRST, 64'h0000_0000_280A_080A);
    write_reg(CFG_ROUTE_LAST, 64'h0000_0000_231E_0C14);
    @(negedge clk);
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 3, 2, 0, 0)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 0, 4, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 3, 16, 7, 8'h10)));
    beats_to_send.push_back(make_beat(ACT_DATA_WR, 2, 2, 32'hDEAD_BEEF));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 11, 0, 0, 0)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 1, 1, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 20, 31, 1, 8'hFC)));
    beats_to_send.push_back(make_beat(ACT_DATA_WR, 0, 4, 32'hFFFF_FFFF));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 37, 0, 0, 0)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 2, 2, 32'h0));
    beats_to_send.push_back(make_beat(ACT_ADDR_WR, 0, 4, cfg_addr(1, 0, 1, 0, 0)));
    beats_to_send.push_back(make_beat(ACT_DATA_RD, 0, 4, 32'h0));
    wait_idle();

    for (int phase = 0; phase < 7; phase++) begin
      load_settings(phase);
      if (phase == 6) steady = 1'b1;
      queue_random(250);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pcicrd_pkg.sv
rtl/pcicrd_cfg_regs.sv
rtl/pcicrd_decode.sv
rtl/pci_config_route_decoder.sv
sim/tb_top.sv
